/* rtl/ubh_pkg.sv */
// Package for the equal-width histogram: field widths, status and register codes,
// and the controller state type. It depends on nothing else.
`default_nettype none
package ubh_pkg;

  localparam int NUM_BINS_DEF = 5;
  localparam int DATA_W       = 16;
  localparam int BIN_OUT_W    = 3;
  localparam int STAT_W       = 2;
  localparam int CFG_IDX_W    = 1;

  localparam logic [DATA_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [DATA_W-1:0] MIN_RST   = 16'h0000;
  localparam logic [DATA_W-1:0] MAX_RST   = 16'h0500;

  localparam logic [STAT_W-1:0] STAT_IN_RANGE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BELOW    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABOVE    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_RD,
    ST_WR
  } st_t;

endpackage
`default_nettype wire

/* rtl/ubh_ifs.sv */
// Valid/ready channel interfaces for the histogram's sample and result requests.
// They use the field widths from ubh_pkg.
`default_nettype none
interface ubh_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ubh_pkg::DATA_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface ubh_out_if;
  logic                              valid;
  logic                              ready;
  logic [ubh_pkg::BIN_OUT_W-1:0]     bin_number;
  logic [ubh_pkg::DATA_W-1:0]        bin_total;
  logic [ubh_pkg::STAT_W-1:0]        range_status;

  modport source (output valid, output bin_number, output bin_total, output range_status,
                  input ready);
  modport sink   (input valid, input bin_number, input bin_total, input range_status,
                  output ready);
endinterface
`default_nettype wire

/* rtl/uniform_bin_histogram.sv */
// Equal-width histogram: bins a signed Q8.8 sample between two programmable edges
// and counts it. Depends on ubh_pkg and the channel interfaces in ubh_ifs.sv.
//
// Channel   Dir  Handshake           Payload
// in_ch     in   valid/ready         sample_value (s16)
// out_ch    out  valid/ready         bin_number (u3), bin_total (u16), range_status (u2)
// cfg_*     in   cfg_we              cfg_index (u1), cfg_wdata (16)
//
// A sample inside the range passes PREP, MUL, the DIV steps, RD and WR before its result is loaded;
// NW = 16 + clog2(NUM_BINS) (19 at five bins) is the bit-serial restoring divider's numerator width.
// A sample outside the range, or an invalid range, goes from PREP straight to RD and WR.
// One request is worked at a time; the next is accepted once the result register is loaded.
// A stalled result holds in the output register while a new request is accepted.
// Synchronous active-low reset clears the controller and all bin counters via valid bits.
`default_nettype none
module uniform_bin_histogram #(
  parameter int NUM_BINS = ubh_pkg::NUM_BINS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ubh_in_if.sink                              in_ch,
  ubh_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ubh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ubh_pkg::DATA_W-1:0]     cfg_wdata
);
  import ubh_pkg::*;

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int NW    = DATA_W + $clog2(NUM_BINS);
  localparam int CNT_W = $clog2(NW);
  localparam int EXT_W = BIN_W + BIN_OUT_W;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  st_t state_r, state_nxt;

  logic signed [DATA_W-1:0] min_r, max_r, samp_r;
  logic [STAT_W-1:0]        status_r;
  logic [DATA_W-1:0]        offset_r, span_r, rem_r;
  logic [NW-1:0]            num_r;
  logic [BIN_W-1:0]         quo_r, bin_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [DATA_W-1:0]        rd_data_r;
  logic                     rd_vld_r;
  logic [NUM_BINS-1:0]      vld_r;
  logic [DATA_W-1:0]        mem [NUM_BINS];

  logic                     out_valid_r;
  logic [BIN_OUT_W-1:0]     out_bin_r;
  logic [DATA_W-1:0]        out_total_r;
  logic [STAT_W-1:0]        out_stat_r;

  logic                     accept, load_out;
  logic [DATA_W:0]          rem_sh, rem_sub;
  logic                     ge;
  logic [BIN_W-1:0]         quo_nxt;
  logic [DATA_W-1:0]        cur_cnt, new_cnt;
  logic [EXT_W-1:0]         bin_ext;
  logic [DATA_W:0]          diff_off, diff_span;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.bin_number   = out_bin_r;
  assign out_ch.bin_total    = out_total_r;
  assign out_ch.range_status = out_stat_r;

  // One restoring step: bring in the next numerator bit and try to take off the span.
  assign rem_sh  = {rem_r, num_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, span_r};
  assign ge      = (rem_sh >= {1'b0, span_r});
  assign quo_nxt = BIN_W'({quo_r, ge});

  assign diff_off  = (DATA_W+1)'(signed'(samp_r)) - (DATA_W+1)'(signed'(min_r));
  assign diff_span = (DATA_W+1)'(signed'(max_r)) - (DATA_W+1)'(signed'(min_r));

  assign cur_cnt  = rd_vld_r ? rd_data_r : '0;
  assign new_cnt  = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign bin_ext  = EXT_W'(bin_r);
  assign load_out = (state_r == ST_WR) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_PREP;
      ST_PREP: begin
        if (max_r > min_r && samp_r >= min_r && samp_r < max_r) state_nxt = ST_MUL;
        else state_nxt = ST_RD;
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WR;
      ST_WR:   if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      min_r       <= MIN_RST;
      max_r       <= MAX_RST;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == ST_WR) vld_r[bin_r] <= 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN: min_r <= cfg_wdata;
          CFG_MAX: max_r <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (accept) samp_r <= in_ch.sample_value;
      ST_PREP: begin
        offset_r <= diff_off[DATA_W-1:0];
        span_r   <= diff_span[DATA_W-1:0];
        priority if (max_r <= min_r) begin
          status_r <= STAT_INVALID;
          bin_r    <= '0;
        end else if (samp_r < min_r) begin
          status_r <= STAT_BELOW;
          bin_r    <= '0;
        end else if (samp_r >= max_r) begin
          status_r <= STAT_ABOVE;
          bin_r    <= LAST_BIN;
        end else begin
          status_r <= STAT_IN_RANGE;
        end
      end
      ST_MUL: begin
        num_r <= NW'(offset_r * NUM_BINS);
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CNT_W'(NW - 1);
      end
      ST_DIV: begin
        num_r <= {num_r[NW-2:0], 1'b0};
        rem_r <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) bin_r <= quo_nxt;
      end
      ST_RD: begin
        rd_data_r <= mem[bin_r];
        rd_vld_r  <= vld_r[bin_r];
      end
      ST_WR: begin
        mem[bin_r] <= new_cnt;
        if (load_out) begin
          out_bin_r   <= bin_ext[BIN_OUT_W-1:0];
          out_total_r <= new_cnt;
          out_stat_r  <= status_r;
        end
      end
      default: ;
    endcase
  end

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_PREP)
    else $error("accepted request did not start classification");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < span_r)
    else $error("divider remainder reached the span");

  a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> status_r == STAT_IN_RANGE)
    else $error("out-of-range sample entered the divider");

  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && out_total_r != '0)
    else $error("loaded result carries a zero count");

  a_above_last: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && status_r == STAT_ABOVE |-> bin_r == LAST_BIN)
    else $error("sample above range not counted in the last bin");

endmodule
`default_nettype wire

/* test/tb_uniform_bin_histogram.sv */
`timescale 1ns / 1ps
// Self-checking testbench for uniform_bin_histogram: directed and random samples over several
// range settings, each result checked against an in-bench model of the bins and counters.
// Depends on ubh_pkg and the channel interfaces in ubh_ifs.sv.
module tb_uniform_bin_histogram;
  import ubh_pkg::*;

  localparam int BINS = NUM_BINS_DEF;

  typedef struct packed {
    logic [BIN_OUT_W-1:0] bin_number;
    logic [DATA_W-1:0]    bin_total;
    logic [STAT_W-1:0]    range_status;
  } bin_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  ubh_in_if  in_ch ();
  ubh_out_if out_ch ();

  uniform_bin_histogram #(.NUM_BINS(BINS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Model state: the programmed range edges and the bin counters.
  logic signed [DATA_W-1:0] range_lo = MIN_RST;
  logic signed [DATA_W-1:0] range_hi = MAX_RST;
  logic [DATA_W-1:0]        bin_tally [BINS];

  logic [DATA_W-1:0] sample_q [$];
  bin_result_t       binned_q [$];
  int                issued = 0;
  int                returned = 0;
  int                fail_count = 0;
  bit                quiet = 1'b0;

  always #1 clk = ~clk;

  function automatic bin_result_t count_sample(logic signed [DATA_W-1:0] s);
    int          lo;
    int          hi;
    int          v;
    int          idx;
    bin_result_t r;
    lo = range_lo;
    hi = range_hi;
    v  = s;
    if (hi <= lo) begin
      idx = 0;
      r.range_status = STAT_INVALID;
    end else if (v < lo) begin
      idx = 0;
      r.range_status = STAT_BELOW;
    end else if (v >= hi) begin
      idx = BINS - 1;
      r.range_status = STAT_ABOVE;
    end else begin
      // The product stays below 2^19 for five bins, so int arithmetic is exact.
      idx = ((v - lo) * BINS) / (hi - lo);
      if (idx > BINS - 1) idx = BINS - 1;
      r.range_status = STAT_IN_RANGE;
    end
    if (bin_tally[idx] != COUNT_MAX) bin_tally[idx] = bin_tally[idx] + 1'b1;
    r.bin_number = idx[BIN_OUT_W-1:0];
    r.bin_total  = bin_tally[idx];
    return r;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Sample driver: presents queued samples and scores each accepted request.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.sample_value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) binned_q.push_back(count_sample(in_ch.sample_value));
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_q.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
          in_ch.valid        <= 1'b1;
          in_ch.sample_value <= sample_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    bin_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(99) >= 24);
      if (out_ch.valid && out_ch.ready) begin
        returned++;
        if (binned_q.size() == 0) begin
          note_failure($sformatf("unexpected result: bin %0d total %0d status %0d",
                                 out_ch.bin_number, out_ch.bin_total, out_ch.range_status));
        end else begin
          want = binned_q.pop_front();
          if (out_ch.bin_number !== want.bin_number || out_ch.bin_total !== want.bin_total ||
              out_ch.range_status !== want.range_status)
            note_failure($sformatf(
              "result mismatch: got bin %0d total %0d status %0d, want bin %0d total %0d status %0d",
              out_ch.bin_number, out_ch.bin_total, out_ch.range_status,
              want.bin_number, want.bin_total, want.range_status));
        end
      end
    end
  end

  task automatic send(logic [DATA_W-1:0] v);
    sample_q.push_back(v);
    issued++;
  endtask

  // Waits until every queued sample has come back as a result.
  task automatic drain();
    while (returned < issued) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_MIN) range_lo = val;
    else range_hi = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_range(int lo, int hi);
    write_reg(CFG_MIN, lo[DATA_W-1:0]);
    write_reg(CFG_MAX, hi[DATA_W-1:0]);
  endtask

  task automatic random_range();
    int a;
    int b;
    a = int'($urandom_range(65535)) - 32768;
    case ($urandom_range(4))
      0: b = int'($urandom_range(65535)) - 32768;
      1: b = a + int'($urandom_range(1, 4));
      2: b = a + int'($urandom_range(1, 3000));
      3: b = a - int'($urandom_range(0, 500));
      default: b = a + 5 * int'($urandom_range(1, 200));
    endcase
    if (b > 32767) b = 32767;
    // Mostly a well-formed range; an inverted one now and then.
    if (a > b && $urandom_range(3) != 0) set_range(b, a);
    else set_range(a, b);
  endtask

  function automatic logic [DATA_W-1:0] pick_sample();
    int lo;
    int hi;
    int pick;
    int v;
    lo   = range_lo;
    hi   = range_hi;
    pick = $urandom_range(99);
    if (pick < 45 && hi > lo) begin
      v = lo + int'($urandom_range(hi - lo - 1));
    end else if (pick < 70) begin
      case ($urandom_range(5))
        0: v = lo - 1;
        1: v = lo;
        2: v = lo + 1;
        3: v = hi - 1;
        4: v = hi;
        default: v = hi + 1;
      endcase
    end else begin
      v = $urandom;
    end
    return v[DATA_W-1:0];
  endfunction

  initial begin
    foreach (bin_tally[i]) bin_tally[i] = '0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_MIN;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample_value = '0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset range 0 to 1280: bins 256 wide, plus both out-of-range sides.
    send(16'h0000); send(16'h00FF); send(16'h0100); send(16'h0300); send(16'h03FF);
    send(16'h0400); send(16'h04FF); send(16'h0500); send(16'hFFFF); send(16'h7FFF);
    send(16'h8000);
    drain();
    // Equal edges make the range invalid.
    set_range(100, 100);
    send(16'h0000); send(16'h7FFF); send(16'h8000);
    drain();
    set_range(-32768, 32767);
    send(16'h8000); send(16'h7FFE); send(16'h7FFF); send(16'h0000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_range(-32768, 32767);
        1: set_range(32767, -32768);
        2: set_range(-32768, -32767);
        3: set_range(32766, 32767);
        default: random_range();
      endcase
      quiet = (ph == 5);
      repeat (50) send(pick_sample());
      drain();
    end
    quiet = 1'b0;

    repeat (40) @(posedge clk);
    if (fail_count == 0 && binned_q.size() == 0) begin
      $display("uniform_bin_histogram regression: pass");
    end else begin
      $display("uniform_bin_histogram regression: fail");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("uniform_bin_histogram regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ubh_pkg.sv
rtl/ubh_ifs.sv
rtl/uniform_bin_histogram.sv
test/tb_uniform_bin_histogram.sv
